// File: rtl/sws_pkg.sv
`default_nettype none

package sws_pkg;

  localparam int unsigned MaxArgBytes = 255;
  localparam int unsigned ArgLenW     = $clog2(MaxArgBytes + 1);

  localparam logic [7:0] SlotsReset = 8'd64;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChBquote  = 8'h60;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [6:0] {
    ModeBetween = 7'b0000001,
    ModePlain   = 7'b0000010,
    ModeEsc     = 7'b0000100,
    ModeSq      = 7'b0001000,
    ModeDq      = 7'b0010000,
    ModeDqEsc   = 7'b0100000,
    ModeIgnore  = 7'b1000000
  } mode_e;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEnd  = 2'd1,
    KindOk   = 2'd2,
    KindErr  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] arg_index;
    logic [7:0] arg_total;
    logic       last;
  } result_t;

  // Up to two results per input byte, filled from r0 upward
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } res_set_t;

  function automatic result_t mk_res(kind_e kind, logic [7:0] b, logic [7:0] idx,
                                     logic [7:0] total);
    result_t r;
    r.kind      = kind;
    r.out_byte  = b;
    r.arg_index = idx;
    r.arg_total = total;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sws_lexer.sv
`default_nettype none

module sws_lexer import sws_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       step_i,
  input  wire logic [7:0] char_i,
  input  wire logic       line_end_i,
  output res_set_t        res_o
);

  mode_e               mode_q, mode_d;
  logic [ArgLenW-1:0]  len_q, len_d;
  logic [7:0]          done_q, done_d;
  logic [7:0]          slots_q;
  logic [7:0]          limit;
  logic                eol;
  logic                special;
  logic                do_plain;
  logic [7:0]          done_inc;

  assign limit    = (slots_q == 8'd0) ? 8'd0 : slots_q - 8'd1;
  assign eol      = line_end_i || (char_i == ChNul);
  assign done_inc = done_q + 8'd1;
  assign special  = (char_i == ChDquote) || (char_i == ChBslash) || (char_i == ChDollar) ||
                    (char_i == ChBquote) || (char_i == ChNewline);

  always_comb begin
    mode_d      = mode_q;
    len_d       = len_q;
    done_d      = done_q;
    res_o       = '0;
    do_plain    = 1'b0;
    if (eol) begin
      if (mode_q == ModePlain || mode_q == ModeEsc) begin
        res_o.r0    = mk_res(KindEnd, 8'd0, done_q, done_inc);
        res_o.r1    = mk_res(KindOk, 8'd0, 8'd0, done_inc);
        res_o.count = 2'd2;
      end else if (mode_q == ModeSq || mode_q == ModeDq || mode_q == ModeDqEsc) begin
        res_o.r0    = mk_res(KindErr, 8'd0, 8'd0, done_q);
        res_o.count = 2'd1;
      end else begin
        res_o.r0    = mk_res(KindOk, 8'd0, 8'd0, done_q);
        res_o.count = 2'd1;
      end
      mode_d = ModeBetween;
      len_d  = '0;
      done_d = 8'd0;
    end else begin
      case (mode_q)
        ModePlain: begin
          do_plain = 1'b1;
        end
        ModeEsc: begin
          if (len_d < ArgLenW'(MaxArgBytes)) begin
            res_o.r0    = mk_res(KindByte, char_i, done_q, done_q);
            res_o.count = 2'd1;
            len_d       = len_d + 1'b1;
          end
          mode_d = ModePlain;
        end
        ModeSq: begin
          if (char_i == ChSquote) begin
            mode_d = ModePlain;
          end else if (len_d < ArgLenW'(MaxArgBytes)) begin
            res_o.r0    = mk_res(KindByte, char_i, done_q, done_q);
            res_o.count = 2'd1;
            len_d       = len_d + 1'b1;
          end
        end
        ModeDq: begin
          if (char_i == ChDquote) begin
            mode_d = ModePlain;
          end else if (char_i == ChBslash) begin
            mode_d = ModeDqEsc;
          end else if (len_d < ArgLenW'(MaxArgBytes)) begin
            res_o.r0    = mk_res(KindByte, char_i, done_q, done_q);
            res_o.count = 2'd1;
            len_d       = len_d + 1'b1;
          end
        end
        ModeDqEsc: begin
          // keep the backslash before a byte it cannot escape
          if (!special && len_d < ArgLenW'(MaxArgBytes)) begin
            res_o.r0    = mk_res(KindByte, ChBslash, done_q, done_q);
            res_o.count = 2'd1;
            len_d       = len_d + 1'b1;
          end
          if (len_d < ArgLenW'(MaxArgBytes)) begin
            if (res_o.count == 2'd0) begin
              res_o.r0 = mk_res(KindByte, char_i, done_q, done_q);
            end else begin
              res_o.r1 = mk_res(KindByte, char_i, done_q, done_q);
            end
            res_o.count = res_o.count + 2'd1;
            len_d       = len_d + 1'b1;
          end
          mode_d = ModeDq;
        end
        ModeIgnore: begin
          mode_d = ModeIgnore;
        end
        default: begin
          if (char_i != ChSpace) begin
            if (done_q >= limit) begin
              mode_d = ModeIgnore;
            end else begin
              len_d    = '0;
              mode_d   = ModePlain;
              do_plain = 1'b1;
            end
          end
        end
      endcase

      if (do_plain) begin
        if (char_i == ChSpace) begin
          res_o.r0    = mk_res(KindEnd, 8'd0, done_q, done_inc);
          res_o.count = 2'd1;
          done_d      = done_inc;
          len_d       = '0;
          mode_d      = ModeBetween;
        end else if (char_i == ChBslash) begin
          mode_d = ModeEsc;
        end else if (char_i == ChSquote) begin
          mode_d = ModeSq;
        end else if (char_i == ChDquote) begin
          mode_d = ModeDq;
        end else if (len_d < ArgLenW'(MaxArgBytes)) begin
          res_o.r0    = mk_res(KindByte, char_i, done_q, done_q);
          res_o.count = 2'd1;
          len_d       = len_d + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBetween;
      len_q   <= '0;
      done_q  <= 8'd0;
      slots_q <= SlotsReset;
    end else begin
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
      if (step_i) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        done_q <= done_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sws_out_buf.sv
`default_nettype none

module sws_out_buf import sws_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire res_set_t    res_i,
  output logic             can_load_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  result_t    buf_q [2];
  logic [1:0] cnt_q;
  logic       head_q;
  logic       out_fire;
  result_t    head_res;
  result_t    ld_r0;
  result_t    ld_r1;

  assign head_res      = buf_q[head_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  // refill only once the last held result leaves
  assign can_load_o    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_fire);

  assign m_axis_tdata = {head_res.arg_total, head_res.arg_index, head_res.out_byte};
  assign m_axis_tuser = head_res.kind;
  assign m_axis_tlast = head_res.last;

  // mark the final result of the request
  always_comb begin
    ld_r0      = res_i.r0;
    ld_r0.last = (res_i.count == 2'd1);
    ld_r1      = res_i.r1;
    ld_r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else if (load_i) begin
      cnt_q  <= res_i.count;
      head_q <= 1'b0;
    end else if (out_fire) begin
      cnt_q  <= cnt_q - 2'd1;
      head_q <= ~head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q[0] <= ld_r0;
      buf_q[1] <= ld_r1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/shell_word_splitter.sv
// Channel   Dir  Group     Payload
// request   in   s_axis_*  tdata = char_byte, tuser = line_end
// result    out  m_axis_*  tdata = out_byte, arg_index, arg_total; tuser = kind; tlast = last
// config    in   cfg_*     arg_slots, written when cfg_we_i is high
//
// A request is held in the input register, then the lexer step writes its
// zero to two results into the two-entry result buffer. One request per cycle is
// taken while each request yields at most one result and m_axis_tready is high; a
// request with two results holds the next one back, as the buffer sends one result per cycle.
// Reset (rst_ni low, asynchronous) empties both stages and starts a fresh line.
// A stalled result buffer holds the lexer step and backs up into s_axis_tready.
`default_nettype none

module shell_word_splitter import sws_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] line_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] arg_index, [23:16] arg_total
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_end_q;
  logic       can_load;
  logic       step;
  res_set_t   res_set;

  assign step          = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser[0];
    end
  end

  sws_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .char_i      (in_char_q),
    .line_end_i  (in_end_q),
    .res_o       (res_set)
  );

  sws_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .res_i         (res_set),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // the second result of a request follows right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of a request missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindOk || m_axis_tuser == KindErr) |-> m_axis_tlast)
    else $error("line status not marked last");

  // a zero byte ends the line, so it never shows as an argument byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == KindByte) == (m_axis_tdata[7:0] != 8'd0)))
    else $error("argument byte field inconsistent with kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> res_set.count != 2'd3)
    else $error("lexer step produced too many results");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;
  import sws_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_char_t;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    logic       typed;
    result_t    res;
  } dir_row_t;

  localparam result_t NoRes        = '0;
  localparam int      PhaseItems   = 100;
  localparam int      NumPhases    = 7;
  localparam int      LongWordLen  = 258;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [0:0]  s_axis_tuser = 1'b0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [23:0] m_axis_tdata;
  wire logic [1:0]  m_axis_tuser;
  wire logic   m_axis_tlast;

  shell_word_splitter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lexer shadow state
  mode_e      lx_mode = ModeBetween;
  int         arg_bytes = 0;
  logic [7:0] args_closed = 8'd0;
  logic [7:0] slot_cfg = SlotsReset;

  result_t    step_res_q[$];
  result_t    pending_res_q[$];
  line_char_t line_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int tx_idle_pct = 24;
  int rx_idle_pct = 49;

  dir_row_t dir_rows[24];

  function automatic void put_res(kind_e k, logic [7:0] b, logic [7:0] idx, logic [7:0] tot);
    result_t r;
    r.kind      = k;
    r.out_byte  = b;
    r.arg_index = idx;
    r.arg_total = tot;
    r.last      = 1'b0;
    step_res_q.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (arg_bytes < MaxArgBytes) begin
      arg_bytes++;
      put_res(KindByte, b, args_closed, args_closed);
    end
  endfunction

  function automatic void close_arg();
    logic [7:0] idx;
    idx = args_closed;
    args_closed = args_closed + 8'd1;
    arg_bytes = 0;
    put_res(KindEnd, 8'd0, idx, args_closed);
  endfunction

  function automatic void unquoted_char(logic [7:0] c);
    case (c)
      ChSpace: begin
        close_arg();
        lx_mode = ModeBetween;
      end
      ChBslash: lx_mode = ModeEsc;
      ChSquote: lx_mode = ModeSq;
      ChDquote: lx_mode = ModeDq;
      default:  add_byte(c);
    endcase
  endfunction

  // Work out the results of one request into step_res_q
  function automatic void lex_step(logic [7:0] c, logic eol);
    logic [7:0] limit;
    kind_e      k;
    result_t    r;
    step_res_q.delete();
    limit = (slot_cfg == 8'd0) ? 8'd0 : slot_cfg - 8'd1;
    if (eol || c == ChNul) begin
      k = KindOk;
      if (lx_mode == ModePlain || lx_mode == ModeEsc)
        close_arg();
      else if (lx_mode == ModeSq || lx_mode == ModeDq || lx_mode == ModeDqEsc)
        k = KindErr;
      put_res(k, 8'd0, 8'd0, args_closed);
      lx_mode = ModeBetween;
      arg_bytes = 0;
      args_closed = 8'd0;
    end else begin
      case (lx_mode)
        ModePlain: unquoted_char(c);
        ModeEsc: begin
          add_byte(c);
          lx_mode = ModePlain;
        end
        ModeSq: begin
          if (c == ChSquote) lx_mode = ModePlain;
          else add_byte(c);
        end
        ModeDq: begin
          if (c == ChDquote) lx_mode = ModePlain;
          else if (c == ChBslash) lx_mode = ModeDqEsc;
          else add_byte(c);
        end
        ModeDqEsc: begin
          if (!(c == ChDquote || c == ChBslash || c == ChDollar || c == ChBquote ||
                c == ChNewline))
            add_byte(ChBslash);
          add_byte(c);
          lx_mode = ModeDq;
        end
        ModeIgnore: ;
        default: begin
          if (c != ChSpace) begin
            if (args_closed >= limit) begin
              lx_mode = ModeIgnore;
            end else begin
              arg_bytes = 0;
              lx_mode = ModePlain;
              unquoted_char(c);
            end
          end
        end
      endcase
    end
    if (step_res_q.size() > 0) begin
      r = step_res_q.pop_back();
      r.last = 1'b1;
      step_res_q.push_back(r);
    end
  endfunction

  // Line text generation
  function automatic void push_ch(logic [7:0] c, logic eol);
    line_char_t lc;
    lc.ch  = c;
    lc.eol = eol;
    line_q.push_back(lc);
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 25)) : 8'($urandom_range(1, 255));
    if (c == ChSpace || c == ChBslash || c == ChSquote || c == ChDquote) c = 8'h7A;
    return c;
  endfunction

  function automatic logic [7:0] pick_dq_escape();
    case ($urandom_range(0, 5))
      0: return ChDquote;
      1: return ChBslash;
      2: return ChDollar;
      3: return ChBquote;
      4: return ChNewline;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void gen_word(bit long_word);
    logic [7:0] c;
    if (long_word) begin
      for (int i = 0; i < LongWordLen; i++) push_ch(8'h41 + 8'(i % 26), 1'b0);
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 4)) push_ch(pick_plain(), 1'b0);
        1: begin
          push_ch(ChBslash, 1'b0);
          push_ch(8'($urandom_range(1, 255)), 1'b0);
        end
        2: begin
          push_ch(ChSquote, 1'b0);
          repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(1, 255));
            if (c == ChSquote) c = ChDquote;
            push_ch(c, 1'b0);
          end
          push_ch(ChSquote, 1'b0);
        end
        default: begin
          push_ch(ChDquote, 1'b0);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              push_ch(ChBslash, 1'b0);
              push_ch(pick_dq_escape(), 1'b0);
            end else begin
              c = 8'($urandom_range(1, 255));
              if (c == ChDquote || c == ChBslash) c = 8'h61;
              push_ch(c, 1'b0);
            end
          end
          push_ch(ChDquote, 1'b0);
        end
      endcase
    end
  endfunction

  function automatic void gen_line(bit long_word);
    int nw;
    repeat ($urandom_range(0, 2)) push_ch(ChSpace, 1'b0);
    nw = $urandom_range(long_word ? 1 : 0, 6);
    for (int i = 0; i < nw; i++) begin
      if (i > 0) repeat ($urandom_range(1, 3)) push_ch(ChSpace, 1'b0);
      gen_word(long_word && i == 0);
    end
    // Broken tails: noise, an open quote, a dangling backslash
    case ($urandom_range(0, 19))
      0: repeat ($urandom_range(1, 12)) push_ch(8'($urandom_range(1, 255)), 1'b0);
      1: push_ch(ChSquote, 1'b0);
      2: push_ch(ChDquote, 1'b0);
      3: begin
        push_ch(ChDquote, 1'b0);
        push_ch(ChBslash, 1'b0);
      end
      4: push_ch(ChBslash, 1'b0);
      default: ;
    endcase
    repeat ($urandom_range(0, 1)) push_ch(ChSpace, 1'b0);
    if ($urandom_range(0, 3) == 0) push_ch(ChNul, 1'b0);
    else push_ch(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // Drive one request, wait for it to be taken, then predict its results
  task automatic send_item(input logic [7:0] c, input logic eol, input logic typed,
                           input result_t res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eol;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    lex_step(c, eol);
    if (typed) begin
      step_res_q.delete();
      step_res_q.push_back(res);
    end
    foreach (step_res_q[i]) pending_res_q.push_back(step_res_q[i]);
    items_sent++;
    if (items_sent < 300) begin
      tx_idle_pct = 24;
      rx_idle_pct = 49;
    end else if (items_sent < 600) begin
      tx_idle_pct = 49;
      rx_idle_pct = 24;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Write the slot count once the block has drained
  task automatic set_slots(input logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slot_cfg = v;
  endtask

  task automatic send_line();
    line_char_t lc;
    while (line_q.size() != 0) begin
      lc = line_q.pop_front();
      send_item(lc.ch, lc.eol, 1'b0, NoRes);
    end
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  // Sample a transfer at the falling edge, where the bus is settled
  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res_q.size() == 0) begin
        $error("result with nothing pending: kind %0d data %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_res_q.pop_front();
        if (m_axis_tuser != want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[7:0] != want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[15:8] != want.arg_index) begin
          $error("arg_index: expected %0d, actual %0d", want.arg_index, m_axis_tdata[15:8]);
          mismatches++;
        end
        if (m_axis_tdata[23:16] != want.arg_total) begin
          $error("arg_total: expected %0d, actual %0d", want.arg_total, m_axis_tdata[23:16]);
          mismatches++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [7:0] slot_plan[NumPhases];
    int         phase_items;
    int         keep;

    dir_rows = '{
      '{ChNul,    1'b1, 1'b1, '{KindOk, 8'd0, 8'd0, 8'd0, 1'b1}},
      '{8'h61,    1'b0, 1'b1, '{KindByte, 8'h61, 8'd0, 8'd0, 1'b1}},
      '{8'hFF,    1'b0, 1'b0, NoRes},
      '{ChSpace,  1'b0, 1'b0, NoRes},
      '{ChBslash, 1'b0, 1'b0, NoRes},
      '{ChSpace,  1'b0, 1'b0, NoRes},
      '{ChSquote, 1'b0, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{ChSquote, 1'b0, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{ChBslash, 1'b0, 1'b0, NoRes},
      '{ChDollar, 1'b0, 1'b0, NoRes},
      '{ChBslash, 1'b0, 1'b0, NoRes},
      '{8'h78,    1'b0, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{ChBslash, 1'b0, 1'b0, NoRes},
      '{ChNul,    1'b0, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{8'hFF,    1'b1, 1'b0, NoRes},
      '{ChDquote, 1'b0, 1'b0, NoRes},
      '{8'h55,    1'b1, 1'b1, '{KindErr, 8'd0, 8'd0, 8'd0, 1'b1}},
      '{ChSquote, 1'b0, 1'b0, NoRes},
      '{8'h71,    1'b1, 1'b1, '{KindErr, 8'd0, 8'd0, 8'd0, 1'b1}}
    };
    slot_plan = '{8'd255, 8'd1, 8'd0, 8'd2, 8'($urandom_range(3, 10)),
                  8'($urandom_range(1, 255)), SlotsReset};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].ch, dir_rows[i].eol, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < NumPhases; p++) begin
      set_slots(slot_plan[p]);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        line_q.delete();
        gen_line(p == 0 && phase_items == 0);
        // Odd phases can stop mid-line so the next write may land inside a line
        if (p % 2 == 1 && phase_items + line_q.size() >= PhaseItems) begin
          keep = $urandom_range(1, line_q.size());
          while (line_q.size() > keep) void'(line_q.pop_back());
        end
        phase_items += line_q.size();
        send_line();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
